/* src/smpq_pkg.sv */
// shared types, codes and widths of the sorted max-priority queue
`timescale 1ns / 1ps

package smpq_pkg;

    // default number of queue entries
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // command from the controller to the datapath
    typedef struct packed {
        logic              exec;
        logic              remove;
        logic [STAT_W-1:0] code;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_stat;

endpackage

/* src/smpq_ctrl.sv */
// controller: input and output handshakes and the status decision
`timescale 1ns / 1ps

module smpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  logic           i_out_ready,
    input  smpq_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output smpq_pkg::t_cmd o_cmd
);

    // state codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // a new transaction is taken when the result slot is free or being emptied
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);

    // command and status code for the datapath
    always_comb begin
        o_cmd.exec   = accept;
        o_cmd.remove = (i_op == smpq_pkg::OP_REMOVE);
        if (i_op == smpq_pkg::OP_REMOVE) begin
            o_cmd.code = i_stat.empty ? smpq_pkg::ST_EMPTY : smpq_pkg::ST_DONE;
        end else begin
            o_cmd.code = i_stat.full ? smpq_pkg::ST_FULL : smpq_pkg::ST_DONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready && !accept) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/smpq_datapath.sv */
// datapath: row of sorted cells, entry count and result register
`timescale 1ns / 1ps

module smpq_datapath #(
    parameter int QUEUE_DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smpq_pkg::t_cmd                       i_cmd,
    input  logic signed [smpq_pkg::VAL_W-1:0]    i_value,
    output smpq_pkg::t_stat                      o_stat,
    output logic signed [smpq_pkg::VAL_W-1:0]    o_removed_value,
    output logic [smpq_pkg::STAT_W-1:0]          o_status,
    output logic [smpq_pkg::CNT_OUT_W-1:0]       o_entry_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic signed [smpq_pkg::VAL_W-1:0] r_entries [QUEUE_DEPTH];
    logic signed [smpq_pkg::VAL_W-1:0] n_entries [QUEUE_DEPTH];
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    logic [QUEUE_DEPTH-1:0]            ge;
    logic                              apply;
    logic [CNT_W+smpq_pkg::CNT_OUT_W-1:0] count_ext;

    assign o_stat.full  = (r_count == DEPTH_CNT);
    assign o_stat.empty = (r_count == '0);
    assign apply        = i_cmd.exec && (i_cmd.code == smpq_pkg::ST_DONE);

    // per cell: compare against the new value, then keep, insert or shift
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic prev_ge;
        logic signed [smpq_pkg::VAL_W-1:0] left_val;
        logic signed [smpq_pkg::VAL_W-1:0] right_val;

        assign ge[g] = (CNT_W'(g) < r_count) && (r_entries[g] >= i_value);

        if (g == 0) begin : g_first
            assign prev_ge  = 1'b0;
            assign left_val = i_value;
        end else begin : g_rest
            assign prev_ge  = ge[g-1];
            assign left_val = r_entries[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_val = r_entries[g];
        end else begin : g_inner
            assign right_val = r_entries[g+1];
        end

        always_comb begin
            if (i_cmd.remove) begin
                n_entries[g] = right_val;
            end else if (ge[g]) begin
                n_entries[g] = r_entries[g];
            end else if (g == 0 || prev_ge) begin
                n_entries[g] = i_value;
            end else begin
                n_entries[g] = left_val;
            end
        end

        // cell storage, only meaningful below the count
        always_ff @(posedge i_clk) begin
            if (apply) r_entries[g] <= n_entries[g];
        end
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (apply) begin
            n_count = i_cmd.remove ? r_count - 1'b1 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register, loaded once per accepted transaction
    assign count_ext = {{smpq_pkg::CNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_removed_value <= (apply && i_cmd.remove) ? r_entries[0] : '0;
            o_status        <= i_cmd.code;
            o_entry_count   <= count_ext[smpq_pkg::CNT_OUT_W-1:0];
        end
    end

endmodule

/* src/sorted_max_priority_queue_unit.sv */
// top level of the sorted max-priority queue
`timescale 1ns / 1ps

// Max-priority queue of signed 32-bit values kept in descending order.
// Input stream: tuser bit 0 selects insert (0) or remove (1), tdata holds
// the value to insert. Every transaction gives one output transaction with
// the removed value (zero unless a remove succeeded), a status code
// (0 done, 1 remove on empty queue, 2 insert dropped because full) and the
// entry count after the operation.
// All cells compare against the incoming value in parallel and shift in one
// step, so one transaction is taken per cycle while the receiver does not
// stall; the result is in the output register in the cycle after acceptance.
// While the receiver stalls, the result is held and no new transaction is
// taken; input ready follows output ready once a result is waiting.
// Reset empties the queue and clears the output valid. The cells themselves
// are not cleared, as only entries below the count are ever read.

module sorted_max_priority_queue_unit #(
    parameter int QUEUE_DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] item_value
    input  logic [smpq_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] operation
    input  logic [smpq_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] removed_value, [33:32] status, [38:34] entry_count, [39] zero
    output logic [smpq_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    smpq_pkg::t_cmd  cmd;
    smpq_pkg::t_stat stat;
    logic signed [smpq_pkg::VAL_W-1:0]   removed_value;
    logic [smpq_pkg::STAT_W-1:0]         status;
    logic [smpq_pkg::CNT_OUT_W-1:0]      entry_count;

    // controller
    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (i_s_axis_tuser[0]),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // datapath
    smpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_s_axis_tdata),
        .o_stat          (stat),
        .o_removed_value (removed_value),
        .o_status        (status),
        .o_entry_count   (entry_count)
    );

    // output packing
    assign o_m_axis_tdata = {1'b0, entry_count, status, removed_value};

endmodule

/* src/smpq_checker.sv */
// port-level checks of the sorted max-priority queue
`timescale 1ns / 1ps

module smpq_checker #(
    parameter int QUEUE_DEPTH = smpq_pkg::DEPTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [smpq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam logic [smpq_pkg::CNT_OUT_W-1:0] DEPTH_OUT =
        smpq_pkg::CNT_OUT_W'(QUEUE_DEPTH);

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[33:32] != 2'd3)
        else $error("undefined status code");

    // remove on empty leaves count zero and value zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[33:32] == smpq_pkg::ST_EMPTY |->
            o_m_axis_tdata[38:34] == '0 && o_m_axis_tdata[31:0] == '0)
        else $error("empty result inconsistent");

    // dropped insert reports a full queue
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[33:32] == smpq_pkg::ST_FULL |->
            o_m_axis_tdata[38:34] == DEPTH_OUT && o_s_axis_tready == i_m_axis_tready)
        else $error("full result inconsistent");

endmodule

bind sorted_max_priority_queue_unit smpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_smpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
